@@ design/mono_lcd_line_rect_drawer_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line and rectangle drawer
// Concurrent checks clocked on clk_i and muted while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MONO_LCD_LINE_RECT_DRAWER_CORE_DEFINES_SVH
`define MONO_LCD_LINE_RECT_DRAWER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MLDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MLDR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MLDR_ASSERT(lbl, prop, msg)
`define MLDR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ design/mldr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldr_pkg
// Shared types, constants and pixel helpers of the line and rectangle drawer.
// ----------------------------------------------------------------------------
package mldr_pkg;

  localparam int unsigned PanelColumns = 120;
  localparam int unsigned PanelPages   = 8;

  // Command codes on the operation field.
  typedef enum logic [1:0] {
    OP_LINE = 2'd0,
    OP_RECT = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // Pixel actions; the unused code acts as off.
  typedef enum logic [1:0] {
    PM_OFF = 2'd0,
    PM_ON  = 2'd1,
    PM_INV = 2'd2
  } pix_mode_e;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    op_e        op;
    logic [6:0] xs;
    logic [6:0] ys;
    logic [6:0] xe;
    logic [6:0] ye;
    logic [1:0] lm;
    logic [1:0] fm;
    logic [6:0] rcol;
    logic [2:0] rpage;
    logic       rd_ok;
  } cmd_t;

  // Status that the back end reports to the front end.
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // New value of one pixel under a pixel action.
  function automatic logic apply_mode(logic [1:0] mode, logic old);
    logic res;
    case (mode)
      PM_ON:   res = 1'b1;
      PM_INV:  res = ~old;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

@@ design/mono_lcd_line_rect_drawer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_lcd_line_rect_drawer_core
// Line, filled-rectangle and page-read engine over a one-bit framebuffer.
// ----------------------------------------------------------------------------
// After reset the block clears the framebuffer, one byte per cycle, all
// PANEL_COLUMNS*PANEL_PAGES bytes (960 by default), with in_ready_o low. The
// framebuffer is a byte memory with one write port and one read port, and
// every drawn pixel is a read-modify-write of its page byte: the byte is read
// in ST_PRD and written back in ST_PWR. A rectangle draws its edges and
// then, where it has one, its interior; a read passes through ST_RRD and
// ST_RRSP, which registers its page byte and raises out_valid_o. A two-entry
// queue lets new commands transfer while one is drawn.
module mono_lcd_line_rect_drawer_core #(
  parameter int unsigned PANEL_COLUMNS = mldr_pkg::PanelColumns,
  parameter int unsigned PANEL_PAGES   = mldr_pkg::PanelPages
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [6:0] x_start_i,
  input  logic [6:0] y_start_i,
  input  logic [6:0] x_end_i,
  input  logic [6:0] y_end_i,
  input  logic [1:0] line_mode_i,
  input  logic [1:0] fill_mode_i,
  input  logic [6:0] read_column_i,
  input  logic [2:0] read_page_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] page_byte_o
);
  import mldr_pkg::*;

  cmd_t         push_cmd, q_cmd;
  logic         push, q_full, q_valid, q_pop;
  back_status_t status;

  mldr_front #(.Cols(PANEL_COLUMNS), .Pages(PANEL_PAGES)) u_front (
    .in_valid_i, .in_ready_o, .operation_i, .x_start_i, .y_start_i,
    .x_end_i, .y_end_i, .line_mode_i, .fill_mode_i, .read_column_i,
    .read_page_i,
    .status_i     (status),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .queue_full_i (q_full)
  );

  mldr_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_cmd),
    .pop_i       (q_pop)
  );

  mldr_back #(.Cols(PANEL_COLUMNS), .Pages(PANEL_PAGES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_cmd),
    .q_pop_o   (q_pop),
    .status_o  (status),
    .out_valid_o, .out_ready_i, .page_byte_o
  );

endmodule

@@ design/mldr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldr_front
// Accepts commands, checks coordinates and forwards kept commands to the queue.
// ----------------------------------------------------------------------------
module mldr_front #(
  parameter int unsigned Cols  = mldr_pkg::PanelColumns,
  parameter int unsigned Pages = mldr_pkg::PanelPages
) (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              operation_i,
  input  logic [6:0]              x_start_i,
  input  logic [6:0]              y_start_i,
  input  logic [6:0]              x_end_i,
  input  logic [6:0]              y_end_i,
  input  logic [1:0]              line_mode_i,
  input  logic [1:0]              fill_mode_i,
  input  logic [6:0]              read_column_i,
  input  logic [2:0]              read_page_i,
  input  mldr_pkg::back_status_t  status_i,
  output logic                    push_o,
  output mldr_pkg::cmd_t          cmd_o,
  input  logic                    queue_full_i
);
  import mldr_pkg::*;

  localparam logic [8:0] ColLim  = 9'(Cols);
  localparam logic [8:0] RowLim  = 9'(Pages * 8);
  localparam logic [5:0] PageLim = 6'(Pages);

  logic on_panel;
  logic keep;

  // A draw command is kept only when all four coordinates lie on the panel.
  assign on_panel = (9'(x_start_i) < ColLim) && (9'(x_end_i) < ColLim) &&
                    (9'(y_start_i) < RowLim) && (9'(y_end_i) < RowLim);

  always_comb begin
    case (operation_i)
      OP_LINE, OP_RECT: keep = on_panel;
      OP_READ:          keep = 1'b1;
      default:          keep = 1'b0;
    endcase
  end

  // Pack the command for the back end.
  always_comb begin
    cmd_o.op    = op_e'(operation_i);
    cmd_o.xs    = x_start_i;
    cmd_o.ys    = y_start_i;
    cmd_o.xe    = x_end_i;
    cmd_o.ye    = y_end_i;
    cmd_o.lm    = line_mode_i;
    cmd_o.fm    = fill_mode_i;
    cmd_o.rcol  = read_column_i;
    cmd_o.rpage = read_page_i;
    cmd_o.rd_ok = (9'(read_column_i) < ColLim) && (6'(read_page_i) < PageLim);
  end

  // No transfer is taken during the clearing pass or while the queue is full.
  assign in_ready_o = !queue_full_i && !status_i.clearing;
  assign push_o     = in_valid_i && in_ready_o && keep;

endmodule

@@ design/mldr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldr_queue
// Two-entry command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mldr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mldr_pkg::cmd_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  output mldr_pkg::cmd_t data_o,
  input  logic           pop_i
);
  import mldr_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ design/mldr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldr_back
// Framebuffer, clearing pass and pixel sequencer for lines, fills and reads.
// ----------------------------------------------------------------------------
`include "mono_lcd_line_rect_drawer_core_defines.svh"
module mldr_back #(
  parameter int unsigned Cols  = mldr_pkg::PanelColumns,
  parameter int unsigned Pages = mldr_pkg::PanelPages
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  mldr_pkg::cmd_t         q_data_i,
  output logic                   q_pop_o,
  output mldr_pkg::back_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             page_byte_o
);
  import mldr_pkg::*;

  localparam int unsigned Depth = Cols * Pages;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [8:0] ColLim = 9'(Cols);
  localparam logic [8:0] RowLim = 9'(Pages * 8);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SETUP = 7'b0000100,
    ST_PRD   = 7'b0001000,
    ST_PWR   = 7'b0010000,
    ST_RRD   = 7'b0100000,
    ST_RRSP  = 7'b1000000
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [AddrW-1:0]  clr_q;
  logic [1:0]        seg_q;
  logic              fill_q;
  logic [6:0]        x_q, y_q;
  logic [6:0]        cnt_q, len_q;
  logic signed [8:0] rem_q;
  logic signed [7:0] dmin_q;
  logic              xmaj_q, mneg_q;
  logic [7:0]        rd_q;
  logic              out_valid_q;
  logic [7:0]        byte_q;

  logic [7:0]        mem [Depth];

  // Segment endpoints: a plain line, or one rectangle edge.
  logic [6:0]        x0, y0, x1, y1;
  logic signed [7:0] dx, dy;
  logic [6:0]        ax, ay;
  logic              xmaj;
  logic              fill_ok;

  always_comb begin
    x0 = cmd_q.xs;
    y0 = cmd_q.ys;
    x1 = cmd_q.xe;
    y1 = cmd_q.ye;
    if (cmd_q.op == OP_RECT) begin
      case (seg_q)
        2'd0:    y1 = cmd_q.ys;
        2'd1:    x1 = cmd_q.xs;
        2'd2:    x0 = cmd_q.xe;
        default: y0 = cmd_q.ye;
      endcase
    end
  end

  assign dx   = $signed({1'b0, x1}) - $signed({1'b0, x0});
  assign dy   = $signed({1'b0, y1}) - $signed({1'b0, y0});
  assign ax   = dx[7] ? 7'(-dx) : dx[6:0];
  assign ay   = dy[7] ? 7'(-dy) : dy[6:0];
  assign xmaj = (ax >= ay);

  // The interior exists only when both sides span more than two pixels.
  assign fill_ok = ({1'b0, cmd_q.xe} > ({1'b0, cmd_q.xs} + 8'd1)) &&
                   ({1'b0, cmd_q.ye} > ({1'b0, cmd_q.ys} + 8'd1));

  // Framebuffer addressing: one byte per column and page.
  logic [AddrW-1:0] pix_addr, rd_addr, raddr, waddr;
  logic             mem_we;
  logic [7:0]       wdata;
  logic [1:0]       cur_mode;

  assign pix_addr = AddrW'(32'(x_q) * Pages + 32'(y_q[6:3]));
  assign rd_addr  = AddrW'(32'(cmd_q.rcol) * Pages + 32'(cmd_q.rpage));
  assign raddr    = (state_q == ST_RRD) ? rd_addr : pix_addr;
  assign mem_we   = (state_q == ST_CLEAR) || (state_q == ST_PWR);
  assign waddr    = (state_q == ST_CLEAR) ? clr_q : pix_addr;
  assign cur_mode = fill_q ? cmd_q.fm : cmd_q.lm;

  always_comb begin
    wdata = rd_q;
    wdata[y_q[2:0]] = apply_mode(cur_mode, rd_q[y_q[2:0]]);
    if (state_q == ST_CLEAR) wdata = 8'h00;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // Minor-axis remainder step that keeps floor(minor_delta * k / length).
  logic signed [8:0] rem_n;
  logic signed [8:0] len_s;
  logic              line_last;

  assign rem_n     = rem_q + 9'(dmin_q);
  assign len_s     = $signed({2'b00, len_q});
  assign line_last = ((cnt_q + 7'd1) == len_q);

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i &&
                   !((q_data_i.op == OP_READ) && out_valid_q);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      seg_q       <= 2'd0;
      fill_q      <= 1'b0;
    end else begin
      if (state_q == ST_RRSP) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == LastAddr) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_pop_o) begin
            cmd_q  <= q_data_i;
            seg_q  <= 2'd0;
            fill_q <= 1'b0;
            state_q <= (q_data_i.op == OP_READ) ? ST_RRD : ST_SETUP;
          end
        end
        ST_SETUP: begin
          cnt_q  <= 7'd0;
          rem_q  <= '0;
          xmaj_q <= xmaj;
          len_q  <= xmaj ? ax : ay;
          dmin_q <= xmaj ? dy : dx;
          mneg_q <= xmaj ? dx[7] : dy[7];
          if ((xmaj ? ax : ay) != 7'd0) begin
            x_q     <= x0;
            y_q     <= y0;
            state_q <= ST_PRD;
          end else if (cmd_q.op == OP_RECT && seg_q != 2'd3) begin
            seg_q <= seg_q + 2'd1;
          end else if (cmd_q.op == OP_RECT && fill_ok) begin
            fill_q  <= 1'b1;
            x_q     <= cmd_q.xs + 7'd1;
            y_q     <= cmd_q.ys + 7'd1;
            state_q <= ST_PRD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_PRD: state_q <= ST_PWR;
        ST_PWR: begin
          if (fill_q) begin
            // Interior walk: rows inside a column, then the next column.
            if (y_q == cmd_q.ye - 7'd1) begin
              y_q <= cmd_q.ys + 7'd1;
              if (x_q == cmd_q.xe - 7'd1) begin
                state_q <= ST_IDLE;
              end else begin
                x_q     <= x_q + 7'd1;
                state_q <= ST_PRD;
              end
            end else begin
              y_q     <= y_q + 7'd1;
              state_q <= ST_PRD;
            end
          end else if (line_last) begin
            if (cmd_q.op == OP_RECT && seg_q != 2'd3) begin
              seg_q   <= seg_q + 2'd1;
              state_q <= ST_SETUP;
            end else if (cmd_q.op == OP_RECT && fill_ok) begin
              fill_q  <= 1'b1;
              x_q     <= cmd_q.xs + 7'd1;
              y_q     <= cmd_q.ys + 7'd1;
              state_q <= ST_PRD;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            // Step the major axis and carry the remainder into the minor one.
            state_q <= ST_PRD;
            cnt_q   <= cnt_q + 7'd1;
            if (xmaj_q) x_q <= mneg_q ? x_q - 7'd1 : x_q + 7'd1;
            else        y_q <= mneg_q ? y_q - 7'd1 : y_q + 7'd1;
            if (!dmin_q[7] && rem_n >= len_s) begin
              rem_q <= rem_n - len_s;
              if (xmaj_q) y_q <= y_q + 7'd1;
              else        x_q <= x_q + 7'd1;
            end else if (dmin_q[7] && rem_n < 0) begin
              rem_q <= rem_n + len_s;
              if (xmaj_q) y_q <= y_q - 7'd1;
              else        x_q <= x_q - 7'd1;
            end else begin
              rem_q <= rem_n;
            end
          end
        end
        ST_RRD: state_q <= ST_RRSP;
        ST_RRSP: begin
          byte_q  <= cmd_q.rd_ok ? rd_q : 8'h00;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign page_byte_o       = byte_q;

  // Checks on the sequencer.
  `MLDR_ASSERT(a_out_from_read, $rose(out_valid_q) |-> $past(state_q == ST_RRSP), "result without read")
  `MLDR_ASSERT(a_pix_on_panel, (state_q == ST_PWR) |-> ((9'(x_q) < ColLim) && (9'(y_q) < RowLim)), "pixel off panel")
  `MLDR_ASSERT(a_line_count, (state_q == ST_PWR && !fill_q) |-> (cnt_q < len_q), "line step overrun")
  `MLDR_ASSERT(a_write_after_read, (state_q == ST_PWR) |-> $past(state_q == ST_PRD), "write without read")

endmodule
